// ===== design/priority_task_scheduler_assert.svh =====
// assertion macros shared by the scheduler modules
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef PRIORITY_TASK_SCHEDULER_ASSERT_SVH
`define PRIORITY_TASK_SCHEDULER_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled while reset is active
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scheduler check failed: same-cycle implication");

// next-cycle implication, disabled while reset is active
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scheduler check failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/pts_pkg.sv =====
// shared constants, command and status codes and control structs of the scheduler
// no dependencies
package pts_pkg;

	localparam int NUM_TASKS_DEF      = 16;
	localparam int NUM_PRIORITIES_DEF = 8;
	localparam int SP_WIDTH_DEF       = 32;
	localparam int PRIO_REQ_W         = 4;

	typedef enum logic [1:0] {
		CMD_READY  = 2'd0,
		CMD_SWITCH = 2'd1,
		CMD_SET_SP = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_BAD_ID = 2'd1,
		STAT_QUEUED = 2'd2
	} status_t;

	// sequencer strobes toward the ready-queue unit
	typedef struct packed {
		logic append_en;
		logic pick_en;
		logic finish_en;
	} qctl_t;

endpackage

// ===== design/pts_sp_mem.sv =====
// saved stack pointer memory: one entry per task plus one for the idle task
// one write port, one read port with registered read data; uses pts_pkg
module pts_sp_mem #(
	parameter int NUM_TASKS = pts_pkg::NUM_TASKS_DEF,
	parameter int SP_WIDTH = pts_pkg::SP_WIDTH_DEF,
	localparam int DEPTH = NUM_TASKS + 1,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  logic [SP_WIDTH-1:0] wr_data,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output logic [SP_WIDTH-1:0] rd_data
);

	logic [SP_WIDTH-1:0] mem [DEPTH];

	// synchronous write and read, read data registered
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/pts_queues.sv =====
// per-priority ready fifos built as linked lists over the task ids
// head/tail/nonempty registers, queued marks and the link memory; uses pts_pkg
`include "priority_task_scheduler_assert.svh"

module pts_queues #(
	parameter int NUM_TASKS = pts_pkg::NUM_TASKS_DEF,
	parameter int NUM_PRIORITIES = pts_pkg::NUM_PRIORITIES_DEF,
	localparam int QIDX_W = $clog2(NUM_TASKS),
	localparam int PRIO_W = $clog2(NUM_PRIORITIES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pts_pkg::qctl_t       ctl,
	input  logic [PRIO_W-1:0]    append_prio,
	input  logic [QIDX_W-1:0]    append_task,
	output logic [NUM_TASKS-1:0] queued,
	output logic                 pick_found,
	output logic [PRIO_W-1:0]    pick_prio,
	output logic [QIDX_W-1:0]    pick_task
);

	logic [QIDX_W-1:0]         head_q [NUM_PRIORITIES];
	logic [QIDX_W-1:0]         tail_q [NUM_PRIORITIES];
	logic [NUM_PRIORITIES-1:0] nonempty_q;
	logic [NUM_TASKS-1:0]      queued_q;
	logic [QIDX_W-1:0]         link_mem [NUM_TASKS];
	logic [QIDX_W-1:0]         link_rd_q;
	logic                      pick_last;
	logic                      pick_found_q;
	logic                      pick_last_q;
	logic [PRIO_W-1:0]         pick_prio_q;

	assign queued = queued_q;

	// highest non-empty priority, level 0 wins
	always_comb begin
		pick_prio = '0;
		for (int i = NUM_PRIORITIES - 1; i >= 0; i--) begin
			if (nonempty_q[i]) begin
				pick_prio = PRIO_W'(i);
			end
		end
	end

	assign pick_found = |nonempty_q;
	assign pick_task  = head_q[pick_prio];
	assign pick_last  = head_q[pick_prio] == tail_q[pick_prio];

	// queue bookkeeping: append, dequeue, then head advance from the link read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PRIORITIES; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
			nonempty_q   <= '0;
			queued_q     <= '0;
			pick_found_q <= 1'b0;
			pick_last_q  <= 1'b0;
			pick_prio_q  <= '0;
		end else begin
			if (ctl.append_en) begin
				if (nonempty_q[append_prio]) begin
					tail_q[append_prio] <= append_task;
				end else begin
					head_q[append_prio]     <= append_task;
					tail_q[append_prio]     <= append_task;
					nonempty_q[append_prio] <= 1'b1;
				end
				queued_q[append_task] <= 1'b1;
			end
			if (ctl.pick_en) begin
				pick_found_q <= pick_found;
				pick_last_q  <= pick_last;
				pick_prio_q  <= pick_prio;
				if (pick_found) begin
					if (pick_last) begin
						nonempty_q[pick_prio] <= 1'b0;
					end
					queued_q[pick_task] <= 1'b0;
				end
			end
			if (ctl.finish_en && pick_found_q && !pick_last_q) begin
				head_q[pick_prio_q] <= link_rd_q;
			end
		end
	end

	// link memory: write at the old tail on append to a non-empty queue, read the successor of the head on pick
	always_ff @(posedge clk) begin
		if (ctl.append_en && nonempty_q[append_prio]) begin
			link_mem[tail_q[append_prio]] <= append_task;
		end
		if (ctl.pick_en) begin
			link_rd_q <= link_mem[pick_task];
		end
	end

	`ASSERT_IMPLIES(a_pick_head_queued, clk, arst_n, ctl.pick_en && pick_found, queued_q[pick_task])
	`ASSERT_IMPLIES(a_append_not_queued, clk, arst_n, ctl.append_en, !queued_q[append_task])
	`ASSERT_NEXT(a_pick_then_finish, clk, arst_n, ctl.pick_en, ctl.finish_en && !ctl.append_en)

endmodule

// ===== design/priority_task_scheduler.sv =====
// top level of the fixed-priority round-robin task scheduler
// channel   signals                                        direction
// in        in_valid/in_stall, cmd, task_id, priority_req,  into the block
//           current_sp, current_running, stack_overflow
// out       out_valid/out_stall, status, next_task,         out of the block
//           next_sp, is_idle, overflow_parked
// ready, set-sp and no-op pass through the execute and output states, a switch through
// execute, pick, done and output; the input opens again once the result is loaded out.
// the extra switch states come from the read-modify-write over the link and sp memories,
// each with registered read data; one item is in work at a time.
// reset clears the sequencer, running task, queues and marks at once; no clearing pass.
// a stalled result holds in the output register while the next item is accepted.
// depends on pts_pkg, pts_queues, pts_sp_mem and priority_task_scheduler_assert.svh
`include "priority_task_scheduler_assert.svh"

module priority_task_scheduler #(
	parameter int NUM_TASKS = pts_pkg::NUM_TASKS_DEF,
	parameter int NUM_PRIORITIES = pts_pkg::NUM_PRIORITIES_DEF,
	parameter int SP_WIDTH = pts_pkg::SP_WIDTH_DEF,
	localparam int TID_W = $clog2(NUM_TASKS + 1),
	localparam int QIDX_W = $clog2(NUM_TASKS),
	localparam int PRIO_W = $clog2(NUM_PRIORITIES)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     cmd,
	input  logic [TID_W-1:0]               task_id,
	input  logic [pts_pkg::PRIO_REQ_W-1:0] priority_req,
	input  logic [SP_WIDTH-1:0]            current_sp,
	input  logic                           current_running,
	input  logic                           stack_overflow,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     status,
	output logic [TID_W-1:0]               next_task,
	output logic [SP_WIDTH-1:0]            next_sp,
	output logic                           is_idle,
	output logic                           overflow_parked
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXEC = 5'b00010,
		ST_PICK = 5'b00100,
		ST_DONE = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	localparam logic [TID_W-1:0] IDLE_ID = TID_W'(NUM_TASKS);

	state_t                           state_q;
	state_t                           state_d;
	pts_pkg::cmd_t                    cmd_q;
	logic [TID_W-1:0]                 tid_q;
	logic [pts_pkg::PRIO_REQ_W-1:0]   preq_q;
	logic [SP_WIDTH-1:0]              sp_q;
	logic                             still_q;
	logic                             ovf_q;
	logic [TID_W-1:0]                 running_task_q;
	logic                             running_valid_q;
	logic [PRIO_W-1:0]                running_prio_q;
	logic [NUM_TASKS-1:0]             ovf_mark_q;
	pts_pkg::status_t                 res_status_q;
	logic [TID_W-1:0]                 res_task_q;
	logic [SP_WIDTH-1:0]              res_sp_q;
	logic                             res_idle_q;
	logic                             res_parked_q;
	logic                             out_valid_q;
	pts_pkg::status_t                 out_status_q;
	logic [TID_W-1:0]                 out_task_q;
	logic [SP_WIDTH-1:0]              out_sp_q;
	logic                             out_is_idle_q;
	logic                             out_parked_q;
	logic                             in_accept;
	logic                             out_free;
	logic                             is_switch;
	logic [QIDX_W-1:0]                tid_idx;
	logic [QIDX_W-1:0]                rt_idx;
	logic                             tid_is_task;
	logic                             tid_ok_sp;
	logic                             rt_is_task;
	logic                             save_en;
	logic                             ovf_now;
	logic                             parked_now;
	logic                             reappend;
	logic [PRIO_W-1:0]                ready_prio;
	pts_pkg::status_t                 status_now;
	pts_pkg::qctl_t                   qctl;
	logic [PRIO_W-1:0]                append_prio;
	logic [QIDX_W-1:0]                append_task;
	logic [NUM_TASKS-1:0]             queued;
	logic                             pick_found;
	logic [PRIO_W-1:0]                pick_prio;
	logic [QIDX_W-1:0]                pick_task;
	logic [TID_W-1:0]                 pick_id;
	logic                             sp_wr_en;
	logic [TID_W-1:0]                 sp_wr_addr;
	logic [SP_WIDTH-1:0]              sp_rd_data;

	assign in_stall  = state_q != ST_IDLE;
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_accept) state_d = ST_EXEC;
			ST_EXEC: state_d = is_switch ? ST_PICK : ST_OUT;
			ST_PICK: state_d = ST_DONE;
			ST_DONE: state_d = ST_OUT;
			ST_OUT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// input item capture
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q   <= pts_pkg::cmd_t'(cmd);
			tid_q   <= task_id;
			preq_q  <= priority_req;
			sp_q    <= current_sp;
			still_q <= current_running;
			ovf_q   <= stack_overflow;
		end
	end

	// command decode for the execute step
	assign is_switch   = cmd_q == pts_pkg::CMD_SWITCH;
	assign tid_idx     = tid_q[QIDX_W-1:0];
	assign rt_idx      = running_task_q[QIDX_W-1:0];
	assign tid_is_task = tid_q < IDLE_ID;
	assign tid_ok_sp   = tid_q <= IDLE_ID;
	assign rt_is_task  = running_task_q < IDLE_ID;
	assign save_en     = is_switch && (sp_q != '0) && running_valid_q;
	assign ovf_now     = ovf_mark_q[rt_idx] || ovf_q;
	assign parked_now  = save_en && rt_is_task && still_q && ovf_now;
	assign reappend    = save_en && rt_is_task && still_q && !ovf_now && !queued[rt_idx];
	assign ready_prio  = (32'(preq_q) > NUM_PRIORITIES - 1) ? PRIO_W'(NUM_PRIORITIES - 1)
		: PRIO_W'(preq_q);

	always_comb begin
		status_now = pts_pkg::STAT_OK;
		case (cmd_q)
			pts_pkg::CMD_READY: begin
				if (!tid_is_task) begin
					status_now = pts_pkg::STAT_BAD_ID;
				end else if (queued[tid_idx]) begin
					status_now = pts_pkg::STAT_QUEUED;
				end
			end
			pts_pkg::CMD_SET_SP: begin
				if (!tid_ok_sp) begin
					status_now = pts_pkg::STAT_BAD_ID;
				end
			end
			default: status_now = pts_pkg::STAT_OK;
		endcase
	end

	// ready-queue strobes and operands
	always_comb begin
		qctl.append_en = (state_q == ST_EXEC)
			&& (((cmd_q == pts_pkg::CMD_READY) && tid_is_task && !queued[tid_idx]) || reappend);
		qctl.pick_en   = state_q == ST_PICK;
		qctl.finish_en = state_q == ST_DONE;
	end

	assign append_prio = is_switch ? running_prio_q : ready_prio;
	assign append_task = is_switch ? rt_idx : tid_idx;

	pts_queues #(
		.NUM_TASKS(NUM_TASKS),
		.NUM_PRIORITIES(NUM_PRIORITIES)
	) u_queues (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(qctl),
		.append_prio(append_prio),
		.append_task(append_task),
		.queued(queued),
		.pick_found(pick_found),
		.pick_prio(pick_prio),
		.pick_task(pick_task)
	);

	// stack pointer memory: saves or sets an entry in execute, reads the chosen task in pick
	assign pick_id    = pick_found ? TID_W'(pick_task) : IDLE_ID;
	assign sp_wr_en   = (state_q == ST_EXEC)
		&& (((cmd_q == pts_pkg::CMD_SET_SP) && tid_ok_sp) || save_en);
	assign sp_wr_addr = is_switch ? running_task_q : tid_q;

	pts_sp_mem #(
		.NUM_TASKS(NUM_TASKS),
		.SP_WIDTH(SP_WIDTH)
	) u_sp_mem (
		.clk(clk),
		.wr_en(sp_wr_en),
		.wr_addr(sp_wr_addr),
		.wr_data(sp_q),
		.rd_en(qctl.pick_en),
		.rd_addr(pick_id),
		.rd_data(sp_rd_data)
	);

	// running task and overflow marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_task_q  <= IDLE_ID;
			running_valid_q <= 1'b0;
			running_prio_q  <= '0;
			ovf_mark_q      <= '0;
		end else begin
			if ((state_q == ST_EXEC) && save_en && rt_is_task && ovf_q) begin
				ovf_mark_q[rt_idx] <= 1'b1;
			end
			if (state_q == ST_PICK) begin
				running_task_q  <= pick_id;
				running_valid_q <= 1'b1;
				running_prio_q  <= pick_found ? pick_prio : '0;
			end
		end
	end

	// result assembly
	always_ff @(posedge clk) begin
		case (state_q)
			ST_EXEC: begin
				res_status_q <= status_now;
				res_task_q   <= '0;
				res_sp_q     <= '0;
				res_idle_q   <= 1'b0;
				res_parked_q <= parked_now;
			end
			ST_PICK: begin
				res_task_q <= pick_id;
				res_idle_q <= !pick_found;
			end
			ST_DONE: res_sp_q <= sp_rd_data;
			default: res_sp_q <= res_sp_q;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			out_status_q  <= res_status_q;
			out_task_q    <= res_task_q;
			out_sp_q      <= res_sp_q;
			out_is_idle_q <= res_idle_q;
			out_parked_q  <= res_parked_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign next_task       = out_task_q;
	assign next_sp         = out_sp_q;
	assign is_idle         = out_is_idle_q;
	assign overflow_parked = out_parked_q;

	`ASSERT_IMPLIES(a_out_from_out_state, clk, arst_n, $rose(out_valid_q), $past(state_q == ST_OUT))
	`ASSERT_IMPLIES(a_idle_result_id, clk, arst_n, out_valid_q && out_is_idle_q, out_task_q == IDLE_ID)
	`ASSERT_NEXT(a_pick_sets_running, clk, arst_n, state_q == ST_PICK, running_valid_q)

endmodule
